// File: rtl/dnlc_pkg.sv
// Shared types, codes and defaults for the directory name lookup cache.
`timescale 1ns / 1ps
package dnlc_pkg;

    // Defaults for the top-level parameters
    localparam int ENTRIES_DEF    = 64;
    localparam int NAME_BYTES_DEF = 32;

    // Queue length field covers the largest supported name buffer
    localparam int LEN_MAX_W = 8;

    // Function codes on the input channel
    localparam logic [2:0] FUNC_LOOKUP = 3'd0;
    localparam logic [2:0] FUNC_ENTER  = 3'd1;
    localparam logic [2:0] FUNC_REMOVE = 3'd2;
    localparam logic [2:0] FUNC_PNODE  = 3'd3;
    localparam logic [2:0] FUNC_PFS    = 3'd4;
    localparam logic [2:0] FUNC_PALL   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_NOCACHE = 2'd2;
    localparam logic [1:0] ST_LONG    = 2'd3;

    // Operation classes handed from front to back
    typedef enum logic [2:0] {
        OP_LOOKUP,
        OP_ENTER,
        OP_REMOVE,
        OP_PNODE,
        OP_PFS,
        OP_PALL,
        OP_FAIL
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [1:0]           status;
        logic [15:0]          dir;
        logic [15:0]          node;
        logic [7:0]           fs;
        logic [LEN_MAX_W-1:0] len;
    } cmd_t;

    // Back-end status seen by the front end
    typedef struct packed {
        logic ready;        // boot clearing pass done
        logic gather_free;  // name buffer no longer needed by the back end
    } back_stat_t;

endpackage

// File: rtl/dnlc_front.sv
// Front end: takes items, gathers name bytes and issues operations.
`timescale 1ns / 1ps
module dnlc_front #(
    parameter int NAME_BYTES = dnlc_pkg::NAME_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_func,
    input  logic [15:0]                    s_dir_handle,
    input  logic [15:0]                    s_node_handle,
    input  logic [7:0]                     s_fs_id,
    input  logic                           s_no_cache,
    input  logic [7:0]                     s_name_char,
    input  logic                           s_name_last,
    output logic                           q_push,
    output dnlc_pkg::cmd_t                 q_cmd,
    input  logic                           q_full,
    input  dnlc_pkg::back_stat_t           bstat,
    input  logic [$clog2(NAME_BYTES)-1:0]  g_raddr,
    output logic [7:0]                     g_rdata
);
    import dnlc_pkg::*;

    localparam int LEN_W = $clog2(NAME_BYTES);

    logic [7:0]       gmem [NAME_BYTES];
    logic [7:0]       g_rdata_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovl_reg, ovl_next;
    logic             end_reg, end_next;
    logic             lock_reg;
    logic             accept, is_name, is_purge, store_byte, lock_set;

    assign s_ready  = ~q_full & bstat.ready & ~lock_reg;
    assign accept   = s_valid & s_ready;
    assign is_name  = (s_func == FUNC_LOOKUP) || (s_func == FUNC_ENTER) ||
                      (s_func == FUNC_REMOVE);
    assign is_purge = (s_func == FUNC_PNODE) || (s_func == FUNC_PFS) ||
                      (s_func == FUNC_PALL);

    // Byte gathering: a zero byte ends the name, one slot is kept spare
    assign store_byte = ~end_reg & (s_name_char != 8'd0) &
                        (len_reg < LEN_W'(NAME_BYTES - 1));

    always_comb begin
        len_next = len_reg;
        ovl_next = ovl_reg;
        end_next = end_reg;
        if (!end_reg) begin
            if (s_name_char == 8'd0) begin
                end_next = 1'b1;
            end else if (store_byte) begin
                len_next = len_reg + LEN_W'(1);
            end else begin
                ovl_next = 1'b1;
            end
        end
    end

    // Operation issued on the last name item or on any purge item
    always_comb begin
        q_cmd        = '0;
        q_cmd.op     = OP_FAIL;
        q_cmd.status = ST_OK;
        q_cmd.dir    = s_dir_handle;
        q_cmd.node   = s_node_handle;
        q_cmd.fs     = s_fs_id;
        q_cmd.len    = LEN_MAX_W'(len_next);
        unique case (s_func)
            FUNC_LOOKUP: q_cmd.op = OP_LOOKUP;
            FUNC_ENTER:  q_cmd.op = OP_ENTER;
            FUNC_REMOVE: q_cmd.op = OP_REMOVE;
            FUNC_PNODE:  q_cmd.op = OP_PNODE;
            FUNC_PFS:    q_cmd.op = OP_PFS;
            FUNC_PALL:   q_cmd.op = OP_PALL;
            default:     q_cmd.op = OP_FAIL;
        endcase
        if (is_name && s_no_cache) begin
            q_cmd.op     = OP_FAIL;
            q_cmd.status = ST_NOCACHE;
        end else if (is_name && ovl_next) begin
            q_cmd.op     = OP_FAIL;
            q_cmd.status = ST_LONG;
        end
    end

    assign q_push   = accept & (is_purge | (is_name & s_name_last));
    assign lock_set = q_push & is_name & ~s_no_cache & ~ovl_next;

    // Gather state and lock on the name buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            ovl_reg  <= 1'b0;
            end_reg  <= 1'b0;
            lock_reg <= 1'b0;
        end else begin
            if (lock_set) begin
                lock_reg <= 1'b1;
            end else if (bstat.gather_free) begin
                lock_reg <= 1'b0;
            end
            if (q_push) begin
                len_reg <= '0;
                ovl_reg <= 1'b0;
                end_reg <= 1'b0;
            end else if (accept && is_name) begin
                len_reg <= len_next;
                ovl_reg <= ovl_next;
                end_reg <= end_next;
            end
        end
    end

    // Name buffer memory
    always_ff @(posedge aclk) begin
        if (accept && is_name && store_byte) begin
            gmem[len_reg] <= s_name_char;
        end
        g_rdata_reg <= gmem[g_raddr];
    end

    assign g_rdata = g_rdata_reg;

endmodule

// File: rtl/dnlc_queue.sv
// Two-entry operation queue between front end and back end.
`timescale 1ns / 1ps
module dnlc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dnlc_pkg::cmd_t din,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output dnlc_pkg::cmd_t dout
);
    import dnlc_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign dout  = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                slot_reg[wr_reg] <= din;
                wr_reg           <= ~wr_reg;
            end
            if (pop) begin
                rd_reg <= ~rd_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/dnlc_back.sv
// Back end: entry search, name compare, enter, invalidate and replacement order.
`timescale 1ns / 1ps
module dnlc_back #(
    parameter int ENTRIES    = dnlc_pkg::ENTRIES_DEF,
    parameter int NAME_BYTES = dnlc_pkg::NAME_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  dnlc_pkg::cmd_t                 q_cmd,
    output dnlc_pkg::back_stat_t           bstat,
    output logic [$clog2(NAME_BYTES)-1:0]  g_raddr,
    input  logic [7:0]                     g_rdata,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [15:0]                    m_found_node
);
    import dnlc_pkg::*;

    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int LEN_W      = $clog2(NAME_BYTES);
    localparam int NAME_DEPTH = ENTRIES << LEN_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    typedef struct packed {
        logic [15:0]      dir;
        logic [15:0]      node;
        logic [7:0]       fs;
        logic [LEN_W-1:0] len;
    } meta_t;

    typedef enum logic [3:0] {
        S_FILL, S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_NAME_RD, S_NAME_CMP,
        S_HIT, S_MISS, S_EVICT_RD, S_EVICT, S_COPY_RD, S_COPY_WR,
        S_WALK_RD, S_WALK_WR, S_RESP
    } state_t;

    function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] x);
        inc_idx = (x == LAST) ? '0 : x + IDX_W'(1);
    endfunction

    state_t             state_reg;
    cmd_t               cmd_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]   e_reg, head_reg, walk_reg, carry_reg, fill_reg;
    logic [LEN_W-1:0]   k_reg;
    logic               fill_resp_reg;
    logic [1:0]         st_reg;
    logic [15:0]        found_reg;
    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic [15:0]        m_found_reg;

    meta_t              meta_mem [ENTRIES];
    meta_t              meta_q, meta_wdata;
    logic               meta_we;
    logic [IDX_W-1:0]   meta_waddr;
    logic [7:0]         name_mem [NAME_DEPTH];
    logic [7:0]         name_q;
    logic               name_we;
    logic [IDX_W-1:0]   order_mem [ENTRIES];
    logic [IDX_W-1:0]   order_q, order_raddr, order_waddr, order_wdata;
    logic               order_we;

    logic [LEN_W-1:0]   cmd_len;
    logic               is_purge, is_name_op, at_last, out_load, dir_ok, purge_hit;

    assign cmd_len    = cmd_reg.len[LEN_W-1:0];
    assign is_purge   = (cmd_reg.op == OP_PNODE) || (cmd_reg.op == OP_PFS);
    assign is_name_op = (cmd_reg.op == OP_LOOKUP) || (cmd_reg.op == OP_ENTER) ||
                        (cmd_reg.op == OP_REMOVE);
    assign at_last    = (e_reg == LAST);
    assign out_load   = (state_reg == S_RESP) && (!m_valid_reg || m_ready);
    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign g_raddr    = k_reg;

    assign dir_ok    = valid_reg[e_reg] && (meta_q.dir == cmd_reg.dir) &&
                       (meta_q.len == cmd_len);
    assign purge_hit = valid_reg[e_reg] &&
                       (((cmd_reg.op == OP_PNODE) &&
                         ((meta_q.node == cmd_reg.node) || (meta_q.dir == cmd_reg.node))) ||
                        ((cmd_reg.op == OP_PFS) && (meta_q.fs == cmd_reg.fs)));

    assign bstat.ready       = !((state_reg == S_FILL) && !fill_resp_reg);
    assign bstat.gather_free = out_load && is_name_op;

    // Memory write controls
    always_comb begin
        meta_we     = 1'b0;
        meta_waddr  = e_reg;
        meta_wdata  = meta_q;
        name_we     = 1'b0;
        order_we    = 1'b0;
        order_waddr = walk_reg;
        order_wdata = carry_reg;
        order_raddr = head_reg;
        case (state_reg)
            S_FILL: begin
                order_we    = 1'b1;
                order_waddr = fill_reg;
                order_wdata = fill_reg;
            end
            S_HIT: begin
                if (cmd_reg.op == OP_ENTER) begin
                    meta_we         = 1'b1;
                    meta_wdata.node = cmd_reg.node;
                    meta_wdata.fs   = cmd_reg.fs;
                end
            end
            S_EVICT: begin
                meta_we    = 1'b1;
                meta_waddr = order_q;
                meta_wdata = '{dir: cmd_reg.dir, node: cmd_reg.node,
                               fs: cmd_reg.fs, len: cmd_len};
            end
            S_COPY_WR: name_we = 1'b1;
            S_WALK_RD: order_raddr = walk_reg;
            S_WALK_WR: begin
                order_raddr = walk_reg;
                order_we    = 1'b1;
            end
            default: ;
        endcase
    end

    // Entry memories, read data registered
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_q <= meta_mem[e_reg];
    end

    always_ff @(posedge aclk) begin
        if (name_we) begin
            name_mem[{e_reg, k_reg}] <= g_rdata;
        end
        name_q <= name_mem[{e_reg, k_reg}];
    end

    // Replacement order: circular list, head_reg is the logical head
    always_ff @(posedge aclk) begin
        if (order_we) begin
            order_mem[order_waddr] <= order_wdata;
        end
        order_q <= order_mem[order_raddr];
    end

    // Sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_FILL;
            fill_reg      <= '0;
            fill_resp_reg <= 1'b0;
            valid_reg     <= '0;
            head_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_FILL: begin
                    if (fill_reg == LAST) begin
                        state_reg <= fill_resp_reg ? S_RESP : S_IDLE;
                    end else begin
                        fill_reg <= fill_reg + IDX_W'(1);
                    end
                end
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg   <= q_cmd;
                        st_reg    <= ST_OK;
                        found_reg <= '0;
                        e_reg     <= '0;
                        unique case (q_cmd.op)
                            OP_FAIL: begin
                                st_reg    <= q_cmd.status;
                                state_reg <= S_RESP;
                            end
                            OP_PALL: begin
                                valid_reg     <= '0;
                                head_reg      <= '0;
                                fill_reg      <= '0;
                                fill_resp_reg <= 1'b1;
                                state_reg     <= S_FILL;
                            end
                            default: state_reg <= S_SCAN_RD;
                        endcase
                    end
                end
                S_SCAN_RD: state_reg <= S_SCAN_CMP;
                S_SCAN_CMP: begin
                    if (is_purge) begin
                        if (purge_hit) begin
                            valid_reg[e_reg] <= 1'b0;
                            carry_reg        <= e_reg;
                            walk_reg         <= head_reg;
                            state_reg        <= S_WALK_RD;
                        end else if (at_last) begin
                            state_reg <= S_RESP;
                        end else begin
                            e_reg     <= e_reg + IDX_W'(1);
                            state_reg <= S_SCAN_RD;
                        end
                    end else if (dir_ok) begin
                        k_reg     <= '0;
                        state_reg <= (cmd_len == '0) ? S_HIT : S_NAME_RD;
                    end else if (at_last) begin
                        state_reg <= S_MISS;
                    end else begin
                        e_reg     <= e_reg + IDX_W'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_NAME_RD: state_reg <= S_NAME_CMP;
                S_NAME_CMP: begin
                    if (name_q == g_rdata) begin
                        if (k_reg == cmd_len - LEN_W'(1)) begin
                            state_reg <= S_HIT;
                        end else begin
                            k_reg     <= k_reg + LEN_W'(1);
                            state_reg <= S_NAME_RD;
                        end
                    end else if (at_last) begin
                        state_reg <= S_MISS;
                    end else begin
                        e_reg     <= e_reg + IDX_W'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_HIT: begin
                    if (cmd_reg.op == OP_LOOKUP) begin
                        found_reg <= meta_q.node;
                        state_reg <= S_RESP;
                    end else if (cmd_reg.op == OP_REMOVE) begin
                        valid_reg[e_reg] <= 1'b0;
                        carry_reg        <= e_reg;
                        walk_reg         <= head_reg;
                        state_reg        <= S_WALK_RD;
                    end else begin
                        state_reg <= S_RESP;
                    end
                end
                S_MISS: begin
                    if (cmd_reg.op == OP_ENTER) begin
                        state_reg <= S_EVICT_RD;
                    end else begin
                        st_reg    <= ST_MISS;
                        state_reg <= S_RESP;
                    end
                end
                S_EVICT_RD: state_reg <= S_EVICT;
                S_EVICT: begin
                    // victim at the head moves to the tail by advancing the head
                    e_reg              <= order_q;
                    valid_reg[order_q] <= 1'b1;
                    head_reg           <= inc_idx(head_reg);
                    k_reg              <= '0;
                    state_reg          <= (cmd_len == '0) ? S_RESP : S_COPY_RD;
                end
                S_COPY_RD: state_reg <= S_COPY_WR;
                S_COPY_WR: begin
                    if (k_reg == cmd_len - LEN_W'(1)) begin
                        state_reg <= S_RESP;
                    end else begin
                        k_reg     <= k_reg + LEN_W'(1);
                        state_reg <= S_COPY_RD;
                    end
                end
                S_WALK_RD: state_reg <= S_WALK_WR;
                S_WALK_WR: begin
                    // shift one slot toward the tail until the entry's old slot
                    carry_reg <= order_q;
                    if (order_q == e_reg) begin
                        if (is_purge && !at_last) begin
                            e_reg     <= e_reg + IDX_W'(1);
                            state_reg <= S_SCAN_RD;
                        end else begin
                            state_reg <= S_RESP;
                        end
                    end else begin
                        walk_reg  <= inc_idx(walk_reg);
                        state_reg <= S_WALK_RD;
                    end
                end
                S_RESP: begin
                    if (out_load) begin
                        m_valid_reg   <= 1'b1;
                        m_status_reg  <= st_reg;
                        m_found_reg   <= found_reg;
                        fill_resp_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found_node = m_found_reg;

endmodule

// File: rtl/directory_name_lookup_cache.sv
// Top level of the directory name lookup cache.
`timescale 1ns / 1ps
// Maps (directory handle, name) to a node handle. Names arrive one byte per
// item and are taken at one item per cycle while s_ready is high; the
// operation runs on the last item and gives one result item. A lookup, enter
// or remove scans the entries in index order and compares the name bytes of
// each entry whose directory and length match; an enter that misses copies
// the name into the victim entry, and a remove moves the entry to the head
// of the replacement order. A purge by node or filesystem scans every entry
// and moves each entry it invalidates to the head of the replacement order;
// purge all rewrites the replacement order. After reset the block runs a
// clearing pass over the order memory before taking its first item. A
// two-entry queue separates item intake from execution. The back end reads
// the gathered name in place, so after the last item of a lookup, enter or
// remove that is not refused, intake pauses until that operation's result is
// loaded into the output register; a result waiting on m_ready therefore
// holds intake once such an operation is pending.
module directory_name_lookup_cache #(
    parameter int ENTRIES    = dnlc_pkg::ENTRIES_DEF,
    parameter int NAME_BYTES = dnlc_pkg::NAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [15:0] s_dir_handle,
    input  logic [15:0] s_node_handle,
    input  logic [7:0]  s_fs_id,
    input  logic        s_no_cache,
    input  logic [7:0]  s_name_char,
    input  logic        s_name_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_found_node
);
    import dnlc_pkg::*;

    localparam int LEN_W = $clog2(NAME_BYTES);

    cmd_t             push_cmd, pop_cmd;
    logic             push, pop, q_full, q_valid;
    back_stat_t       bstat;
    logic [LEN_W-1:0] g_raddr;
    logic [7:0]       g_rdata;

    dnlc_front #(.NAME_BYTES(NAME_BYTES)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_dir_handle  (s_dir_handle),
        .s_node_handle (s_node_handle),
        .s_fs_id       (s_fs_id),
        .s_no_cache    (s_no_cache),
        .s_name_char   (s_name_char),
        .s_name_last   (s_name_last),
        .q_push        (push),
        .q_cmd         (push_cmd),
        .q_full        (q_full),
        .bstat         (bstat),
        .g_raddr       (g_raddr),
        .g_rdata       (g_rdata)
    );

    dnlc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_cmd),
        .full    (q_full),
        .pop     (pop),
        .valid   (q_valid),
        .dout    (pop_cmd)
    );

    dnlc_back #(.ENTRIES(ENTRIES), .NAME_BYTES(NAME_BYTES)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_pop        (pop),
        .q_cmd        (pop_cmd),
        .bstat        (bstat),
        .g_raddr      (g_raddr),
        .g_rdata      (g_rdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found_node (m_found_node)
    );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the directory name lookup cache.
`timescale 1ns / 1ps
module testbench;
    import dnlc_pkg::*;

    localparam int NUM_ENTRIES = 64;
    localparam int NUM_BUCKETS = 32;
    localparam int NAME_MAX    = 32;
    localparam int STALL_LIMIT = 40000;
    localparam int DRAIN_WAIT  = 300;
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;

    typedef struct {
        logic [2:0]  func;
        logic [15:0] dir;
        logic [15:0] node;
        logic [7:0]  fs;
        logic        no_cache;
        logic [7:0]  ch;
        logic        last;
        bit          hold;  // wait until all answers are back before sending
    } cache_item_t;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] node;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = '0;
    logic [15:0] s_dir_handle = '0;
    logic [15:0] s_node_handle = '0;
    logic [7:0]  s_fs_id = '0;
    logic        s_no_cache = 1'b0;
    logic [7:0]  s_name_char = '0;
    logic        s_name_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_found_node;

    cache_item_t pending_items[$];
    answer_t     expected_answers[$];
    cache_item_t cur_item;
    bit          item_taken = 0;
    bit          quiet = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          idle_cycles = 0;
    int          errors = 0;
    int          n_items = 0;
    int          n_answers = 0;
    int          n_hits = 0;
    int          n_evicts = 0;

    // Predictor state
    logic [7:0]  gath_buf[NAME_MAX];
    int          gath_len;
    int          gath_bkt;
    bit          gath_long;
    bit          gath_done;
    bit          ent_valid[NUM_ENTRIES];
    int          ent_bkt[NUM_ENTRIES];
    logic [15:0] ent_dir[NUM_ENTRIES];
    logic [15:0] ent_node[NUM_ENTRIES];
    logic [7:0]  ent_fs[NUM_ENTRIES];
    int          ent_len[NUM_ENTRIES];
    logic [7:0]  ent_name[NUM_ENTRIES][NAME_MAX];
    int          evict_order[NUM_ENTRIES];

    directory_name_lookup_cache i_dut (.*);

    always #10 aclk = ~aclk;

    function automatic void gather_reset();
        gath_len  = 0;
        gath_bkt  = 0;
        gath_long = 0;
        gath_done = 0;
    endfunction

    function automatic void move_to_head(int e);
        int p;
        p = 0;
        while (evict_order[p] != e) p++;
        for (int k = p; k > 0; k--) evict_order[k] = evict_order[k-1];
        evict_order[0] = e;
    endfunction

    function automatic int find_entry(logic [15:0] dir);
        bit same;
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            if (ent_valid[e] && ent_bkt[e] == gath_bkt && ent_dir[e] == dir
                    && ent_len[e] == gath_len) begin
                same = 1;
                for (int k = 0; k < gath_len; k++)
                    if (ent_name[e][k] != gath_buf[k]) same = 0;
                if (same) return e;
            end
        end
        return NUM_ENTRIES;
    endfunction

    // Predict the answer (if any) of one accepted item
    function automatic void predict_cache(cache_item_t it);
        answer_t a;
        int e;
        a.status = ST_OK;
        a.node   = '0;
        if (it.func > FUNC_PALL) return;
        if (it.func >= FUNC_PNODE) begin
            for (e = 0; e < NUM_ENTRIES; e++) begin
                if (it.func == FUNC_PALL) ent_valid[e] = 0;
                else if (ent_valid[e] &&
                         ((it.func == FUNC_PNODE &&
                           (ent_node[e] == it.node || ent_dir[e] == it.node)) ||
                          (it.func == FUNC_PFS && ent_fs[e] == it.fs))) begin
                    ent_valid[e] = 0;
                    move_to_head(e);
                end
            end
            if (it.func == FUNC_PALL)
                for (e = 0; e < NUM_ENTRIES; e++) evict_order[e] = e;
            gather_reset();
            expected_answers.push_back(a);
            return;
        end
        // name byte
        if (!gath_done) begin
            if (it.ch == 0) gath_done = 1;
            else begin
                gath_bkt = (gath_bkt + it.ch) % NUM_BUCKETS;
                if (gath_len < NAME_MAX - 1) begin
                    gath_buf[gath_len] = it.ch;
                    gath_len++;
                end else gath_long = 1;
            end
        end
        if (!it.last) return;
        if (it.no_cache) a.status = ST_NOCACHE;
        else if (gath_long) a.status = ST_LONG;
        else begin
            e = find_entry(it.dir);
            if (it.func == FUNC_LOOKUP) begin
                if (e < NUM_ENTRIES) begin
                    a.node = ent_node[e];
                    n_hits++;
                end else a.status = ST_MISS;
            end else if (it.func == FUNC_ENTER) begin
                if (e >= NUM_ENTRIES) begin
                    e = evict_order[0];
                    if (ent_valid[e]) n_evicts++;
                    for (int k = 0; k < NUM_ENTRIES - 1; k++)
                        evict_order[k] = evict_order[k+1];
                    evict_order[NUM_ENTRIES-1] = e;
                    ent_valid[e] = 1;
                    ent_bkt[e]   = gath_bkt;
                    ent_dir[e]   = it.dir;
                    ent_len[e]   = gath_len;
                    for (int k = 0; k < gath_len; k++) ent_name[e][k] = gath_buf[k];
                end
                ent_node[e] = it.node;
                ent_fs[e]   = it.fs;
            end else begin
                if (e < NUM_ENTRIES) begin
                    ent_valid[e] = 0;
                    move_to_head(e);
                end else a.status = ST_MISS;
            end
        end
        gather_reset();
        expected_answers.push_back(a);
    endfunction

    // Queue one item
    task automatic add_item(logic [2:0] f, logic [15:0] d, logic [15:0] n, logic [7:0] fs,
                            logic nc, logic [7:0] ch, logic last, bit hold = 0);
        cache_item_t it;
        it.func = f; it.dir = d; it.node = n; it.fs = fs;
        it.no_cache = nc; it.ch = ch; it.last = last; it.hold = hold;
        pending_items.push_back(it);
    endtask

    // Queue a name operation; the bytes go out one per item, maybe with noise
    task automatic add_name_op(logic [2:0] f, logic [15:0] d, logic [15:0] n,
                               logic [7:0] fs, logic nc, logic [7:0] bytes[$]);
        logic [2:0] mid;
        if (bytes.size() == 0) bytes.push_back(8'd0);
        foreach (bytes[k]) begin
            if ($urandom_range(0, 24) == 0)
                add_item($urandom_range(0, 1) ? FUNC_SPARE6 : FUNC_SPARE7, 16'($urandom),
                         16'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                         1'($urandom));
            mid = 3'($urandom_range(0, 2));
            if (k == bytes.size() - 1)
                add_item(f, d, n, fs, nc, bytes[k], 1'b1);
            else
                add_item(mid, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
                         bytes[k], 1'b0);
        end
    endtask

    function automatic void fill_name(ref logic [7:0] q[$], input int len,
                                      input bit wide);
        q.delete();
        for (int k = 0; k < len; k++)
            q.push_back(wide ? 8'($urandom_range(1, 255)) : 8'($urandom_range(97, 100)));
    endfunction

    // Stimulus
    initial begin
        logic [7:0] nm[$];
        logic [2:0] f;
        int r;
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            ent_valid[e] = 0;
            evict_order[e] = e;
        end
        gather_reset();

        // Directed part
        nm = '{8'd97};
        add_name_op(FUNC_ENTER, 16'd1, 16'hFFFF, 8'hFF, 1'b0, nm);
        add_name_op(FUNC_LOOKUP, 16'd1, 16'd0, 8'd0, 1'b0, nm);
        add_name_op(FUNC_LOOKUP, 16'd2, 16'd0, 8'd0, 1'b0, nm);
        add_name_op(FUNC_REMOVE, 16'd2, 16'd0, 8'd0, 1'b0, nm);
        add_name_op(FUNC_LOOKUP, 16'd1, 16'd0, 8'd0, 1'b1, nm);
        add_name_op(FUNC_REMOVE, 16'd1, 16'd0, 8'd0, 1'b0, nm);
        nm = '{};
        add_name_op(FUNC_ENTER, 16'hFFFF, 16'd5, 8'd0, 1'b0, nm);
        add_name_op(FUNC_LOOKUP, 16'hFFFF, 16'd0, 8'd0, 1'b0, nm);
        fill_name(nm, NAME_MAX - 1, 1);
        add_name_op(FUNC_ENTER, 16'd0, 16'd7, 8'd3, 1'b0, nm);
        add_name_op(FUNC_LOOKUP, 16'd0, 16'd0, 8'd0, 1'b0, nm);
        fill_name(nm, NAME_MAX, 1);
        nm[0] = 8'hFF;
        add_name_op(FUNC_ENTER, 16'd0, 16'd7, 8'd3, 1'b0, nm);
        nm = '{8'd98, 8'd0, 8'd255, 8'd128};   // terminator, then ignored bytes
        add_name_op(FUNC_ENTER, 16'd3, 16'd9, 8'd3, 1'b0, nm);
        add_item(FUNC_SPARE7, 16'd3, 16'd0, 8'd0, 1'b0, 8'd99, 1'b1);
        nm = '{8'd98};
        add_name_op(FUNC_LOOKUP, 16'd3, 16'd0, 8'd0, 1'b0, nm);
        add_item(FUNC_LOOKUP, 16'd3, 16'd0, 8'd0, 1'b0, 8'd100, 1'b0);
        add_item(FUNC_PNODE, 16'd0, 16'd9, 8'd0, 1'b0, 8'd0, 1'b0, 1);
        add_name_op(FUNC_LOOKUP, 16'd3, 16'd0, 8'd0, 1'b0, nm);
        add_item(FUNC_PNODE, 16'd0, 16'hFFFF, 8'd0, 1'b0, 8'd0, 1'b1);
        add_item(FUNC_PFS, 16'd0, 16'd0, 8'd3, 1'b0, 8'd0, 1'b1);
        add_item(FUNC_PALL, 16'd0, 16'd0, 8'd0, 1'b0, 8'd0, 1'b0);

        // Random part: mostly well-formed operations on a small key space
        while (pending_items.size() < 560) begin
            r = $urandom_range(0, 99);
            if (r < 3) fill_name(nm, $urandom_range(NAME_MAX - 1, NAME_MAX + 4), 1);
            else if (r < 10) fill_name(nm, $urandom_range(0, 6), 1);
            else fill_name(nm, $urandom_range(0, 3), 0);
            if ($urandom_range(0, 19) == 0 && nm.size() > 1)
                nm[$urandom_range(0, nm.size() - 2)] = 8'd0;
            r = $urandom_range(0, 99);
            if (r < 85) begin
                f = (r < 40) ? FUNC_ENTER : (r < 70) ? FUNC_LOOKUP : FUNC_REMOVE;
                add_name_op(f, ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 3)),
                            ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 15)),
                            ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 3)),
                            $urandom_range(0, 15) == 0, nm);
            end else begin
                // broken sequence: a purge, in part of the cases after a partial name
                if (r < 92)
                    for (int k = 0; k < $urandom_range(0, 3); k++)
                        add_item(FUNC_LOOKUP, 16'($urandom), 16'($urandom), 8'($urandom),
                                 1'($urandom), 8'($urandom), 1'b0);
                f = (r < 95) ? FUNC_PNODE : (r < 99) ? FUNC_PFS : FUNC_PALL;
                add_item(f, 16'($urandom), 16'($urandom_range(0, 15)),
                         8'($urandom_range(0, 3)), 1'($urandom), 8'($urandom),
                         1'($urandom), $urandom_range(0, 9) == 0);
            end
        end

        // Wait for the sender to finish, then for all answers
        while (pending_items.size() != 0 || s_valid) @(posedge aclk);
        while (expected_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("Covered %0d items and %0d answers: %0d lookup hits, %0d evictions.",
                 n_items, n_answers, n_hits, n_evicts);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Reset release
    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: new item at the falling edge
    always @(negedge aclk) begin
        quiet = pending_items.size() < 80;
        if (aresetn && (!s_valid || item_taken)) begin
            item_taken = 0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].hold && expected_answers.size() != 0)) begin
                cur_item = pending_items.pop_front();
                s_func        <= cur_item.func;
                s_dir_handle  <= cur_item.dir;
                s_node_handle <= cur_item.node;
                s_fs_id       <= cur_item.fs;
                s_no_cache    <= cur_item.no_cache;
                s_name_char   <= cur_item.ch;
                s_name_last   <= cur_item.last;
                s_valid       <= 1'b1;
                if (!quiet && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 19);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result back-pressure
    always @(negedge aclk) begin
        if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 19);
        end
    end

    // Monitor: predict on intake, check answers, watch for a hang
    always @(posedge aclk) begin
        answer_t exp_a;
        if (aresetn) begin
            idle_cycles++;
            if (s_valid && s_ready) begin
                predict_cache(cur_item);
                item_taken = 1;
                n_items++;
                idle_cycles = 0;
            end
            if (m_valid && m_ready) begin
                idle_cycles = 0;
                n_answers++;
                if (expected_answers.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected answer status %0d node %0h",
                             $time, m_status, m_found_node);
                end else begin
                    exp_a = expected_answers.pop_front();
                    if (m_status !== exp_a.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_a.status, m_status);
                    end
                    if (m_found_node !== exp_a.node) begin
                        errors++;
                        $display("%0t: found_node expected %0h actual %0h",
                                 $time, exp_a.node, m_found_node);
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

endmodule
